// File: hw/rtl/clm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clm_pkg
// shared constants and types for the collatz max cycle length unit
// ----------------------------------------------------------------------------
package clm_pkg;

    localparam int MEMO_ENTRIES = 1024;
    localparam int TRAJ_BITS    = 64;
    localparam int MEMO_AW      = (MEMO_ENTRIES > 1) ? $clog2(MEMO_ENTRIES) : 1;
    localparam int BOUND_W      = 20;
    localparam int LEN_W        = 10;

    typedef logic [BOUND_W-1:0]   t_bound;
    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [TRAJ_BITS-1:0] t_traj;
    typedef logic [MEMO_AW-1:0]   t_maddr;

    localparam t_len LEN_MAX = {LEN_W{1'b1}};

    typedef struct packed {
        logic   start;
        t_bound value;
    } t_walk_req;

    typedef struct packed {
        logic ready;
        logic done;
        t_len length;
    } t_walk_rsp;

endpackage

// File: hw/rtl/clm_memo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clm_memo
// length memo ram, one read and one write port, clear sweep after reset
// ----------------------------------------------------------------------------
module clm_memo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  clm_pkg::t_maddr i_rd_addr,
    output clm_pkg::t_len   o_rd_data,
    input  logic           i_wr_en,
    input  clm_pkg::t_maddr i_wr_addr,
    input  clm_pkg::t_len   i_wr_data,
    output logic           o_ready
);
    import clm_pkg::*;

    t_len   r_mem [MEMO_ENTRIES];
    t_len   r_rd_data;
    logic   r_clearing;
    t_maddr r_clr_addr;

    logic   w_we;
    t_maddr w_wa;
    t_len   w_wd;

    assign w_we = r_clearing | i_wr_en;
    assign w_wa = r_clearing ? r_clr_addr : i_wr_addr;
    assign w_wd = r_clearing ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == MEMO_AW'(MEMO_ENTRIES - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + t_maddr'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = ~r_clearing;

endmodule

// File: hw/rtl/clm_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clm_walker
// walks one trajectory a step per cycle, memo lookup on every value
// ----------------------------------------------------------------------------
module clm_walker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clm_pkg::t_walk_req i_req,
    output clm_pkg::t_walk_rsp o_rsp
);
    import clm_pkg::*;

    localparam logic [1:0] W_IDLE = 2'd0;
    localparam logic [1:0] W_STEP = 2'd1;
    localparam logic [1:0] W_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    t_traj      r_v, n_v;
    t_len       r_len, n_len;
    t_bound     r_start, n_start;

    t_len       w_rd_data;
    t_maddr     w_rd_addr;
    logic       w_mem_ready;
    logic       w_hit;
    t_traj      w_next;
    logic [LEN_W:0] w_inc;
    logic [LEN_W:0] w_memo_sum;
    t_len       w_len_step;
    t_len       w_len_memo;
    logic       w_wr_en;

    clm_memo u_memo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_start[MEMO_AW-1:0]),
        .i_wr_data (r_len),
        .o_ready   (w_mem_ready)
    );

    assign w_hit      = (r_v < t_traj'(MEMO_ENTRIES)) && (w_rd_data != '0);
    assign w_next     = r_v[0] ? (r_v + (r_v >> 1) + t_traj'(1)) : (r_v >> 1);
    assign w_inc      = {1'b0, r_len} + (r_v[0] ? (LEN_W+1)'(2) : (LEN_W+1)'(1));
    assign w_len_step = (w_inc > {1'b0, LEN_MAX}) ? LEN_MAX : w_inc[LEN_W-1:0];
    assign w_memo_sum = {1'b0, r_len} + {1'b0, w_rd_data} - (LEN_W+1)'(1);
    assign w_len_memo = (w_memo_sum > {1'b0, LEN_MAX}) ? LEN_MAX : w_memo_sum[LEN_W-1:0];
    assign w_wr_en    = (r_state == W_DONE) && (r_start < t_bound'(MEMO_ENTRIES));

    always_comb begin
        n_state   = r_state;
        n_v       = r_v;
        n_len     = r_len;
        n_start   = r_start;
        w_rd_addr = r_v[MEMO_AW-1:0];
        case (r_state)
            W_IDLE: begin
                w_rd_addr = i_req.value[MEMO_AW-1:0];
                if (i_req.start) begin
                    n_v     = t_traj'(i_req.value);
                    n_len   = LEN_W'(1);
                    n_start = i_req.value;
                    n_state = W_STEP;
                end
            end
            W_STEP: begin
                w_rd_addr = w_next[MEMO_AW-1:0];
                if (r_v == t_traj'(1)) begin
                    n_state = W_DONE;
                end else if (w_hit) begin
                    n_len   = w_len_memo;
                    n_state = W_DONE;
                end else begin
                    n_v   = w_next;
                    n_len = w_len_step;
                    if (w_next == '0) begin
                        n_state = W_DONE;
                    end
                end
            end
            W_DONE: begin
                n_state = W_IDLE;
            end
            default: begin
                n_state = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_len   <= n_len;
        r_start <= n_start;
    end

    assign o_rsp.ready  = w_mem_ready && (r_state == W_IDLE);
    assign o_rsp.done   = (r_state == W_DONE);
    assign o_rsp.length = r_len;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !o_rsp.done)
        else $error("walk done held longer than one cycle");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == W_STEP) || (r_state == W_DONE) |-> r_len != '0)
        else $error("walk length is zero");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == W_IDLE) && w_mem_ready)
        else $error("walk started while busy");

endmodule

// File: hw/rtl/collatz_max_cycle_length_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collatz_max_cycle_length_unit
// greatest collatz cycle length over an inclusive range of start values
// ----------------------------------------------------------------------------
// after reset all 1024 memo entries are cleared while s_axis_tready is low
// each start value is walked until it reaches 1 or hits the memo; a request
// walks lo and then hi/2+1..hi, and the greatest length goes to the
// output register; one request is worked at a time
// reset is synchronous active low and clears control state and the memo
// ----------------------------------------------------------------------------
module collatz_max_cycle_length_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // first_bound[19:0], second_bound[39:20]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // max_cycle_length[9:0], zero fill
);
    import clm_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_GO   = 2'd1;
    localparam logic [1:0] T_WAIT = 2'd2;
    localparam logic [1:0] T_OUT  = 2'd3;

    logic [1:0] r_state;
    t_bound     r_cur;
    t_bound     r_hi;
    t_bound     r_scan;
    logic       r_first;
    t_len       r_best;
    logic       r_out_valid;
    t_len       r_out_len;

    t_walk_req  w_req;
    t_walk_rsp  w_rsp;
    t_bound     w_a;
    t_bound     w_b;
    t_bound     w_lo;
    t_bound     w_hi;
    t_bound     w_half;
    logic       w_accept;
    logic       w_load_out;

    clm_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_a    = (s_axis_tdata[19:0] == '0) ? t_bound'(1) : s_axis_tdata[19:0];
    assign w_b    = (s_axis_tdata[39:20] == '0) ? t_bound'(1) : s_axis_tdata[39:20];
    assign w_lo   = (w_b < w_a) ? w_b : w_a;
    assign w_hi   = (w_b < w_a) ? w_a : w_b;
    assign w_half = (w_hi >> 1) + t_bound'(1);

    assign s_axis_tready = (r_state == T_IDLE) && w_rsp.ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load_out    = (r_state == T_OUT) && (!r_out_valid || m_axis_tready);

    assign w_req.start = (r_state == T_GO);
    assign w_req.value = r_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                T_IDLE: begin
                    if (w_accept) begin
                        r_state <= T_GO;
                    end
                end
                T_GO: begin
                    r_state <= T_WAIT;
                end
                T_WAIT: begin
                    if (w_rsp.done) begin
                        if (!r_first && (r_cur == r_hi)) begin
                            r_state <= T_OUT;
                        end else begin
                            r_state <= T_GO;
                        end
                    end
                end
                T_OUT: begin
                    if (w_load_out) begin
                        r_state <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur   <= w_lo;
            r_hi    <= w_hi;
            r_scan  <= (w_half < w_lo) ? w_lo : w_half;
            r_first <= 1'b1;
            r_best  <= '0;
        end else if ((r_state == T_WAIT) && w_rsp.done) begin
            if (w_rsp.length > r_best) begin
                r_best <= w_rsp.length;
            end
            if (r_first) begin
                r_first <= 1'b0;
                r_cur   <= r_scan;
            end else if (r_cur != r_hi) begin
                r_cur <= r_cur + t_bound'(1);
            end
        end
        if (w_load_out) begin
            r_out_len <= r_best;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_len};

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == T_WAIT)
        else $error("walk finished outside wait state");

    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_WAIT) |-> r_cur <= r_hi)
        else $error("scan value beyond upper bound");

    a_result_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> m_axis_tdata[9:0] != '0)
        else $error("result length is zero");

endmodule

// File: tb/collatz_max_cycle_length_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collatz_max_cycle_length_unit_checker
// watches both stream channels, predicts and compares each max cycle length
// ----------------------------------------------------------------------------
// every accepted request is run through a local copy of the range scan, with
// its own length memo that is cleared at reset and kept across requests; the
// predicted length is queued and every accepted result is compared against
// the oldest entry. failures are counted and the first ten are printed
// ----------------------------------------------------------------------------
module collatz_max_cycle_length_unit_checker
    import clm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,    // first_bound[19:0], second_bound[39:20]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,    // max_cycle_length[9:0], zero fill
    output int          o_fail_count,
    output int          o_pending
);

    t_len memo_len [MEMO_ENTRIES];
    t_len expected_len_q [$];
    int   fail_cnt = 0;
    t_len got_len;
    t_len want_len;

    function automatic int unsigned sat_len(input int unsigned sum);
        return (sum > LEN_MAX) ? int'(LEN_MAX) : sum;
    endfunction

    function automatic int unsigned walk_cycle_length(input t_bound start_val);
        t_traj       v;
        int unsigned len;
        logic        walk_done;
        v         = t_traj'(start_val);
        len       = 1;
        walk_done = (v == t_traj'(1));
        while (!walk_done) begin
            if (v < MEMO_ENTRIES && memo_len[v[MEMO_AW-1:0]] != '0) begin
                // known length further down the trajectory
                len       = sat_len(len + memo_len[v[MEMO_AW-1:0]] - 1);
                walk_done = 1'b1;
            end else begin
                if (!v[0]) begin
                    v   = v >> 1;
                    len = sat_len(len + 1);
                end else begin
                    v   = v + (v >> 1) + t_traj'(1);
                    len = sat_len(len + 2);
                end
                walk_done = (v == t_traj'(1)) || (v == t_traj'(0));
            end
        end
        if (start_val < MEMO_ENTRIES)
            memo_len[start_val[MEMO_AW-1:0]] = t_len'(len);
        return len;
    endfunction

    function automatic t_len range_max_length(input t_bound bound_a, input t_bound bound_b);
        t_bound      lo;
        t_bound      hi;
        int unsigned best;
        int unsigned cur;
        int unsigned scan_from;
        int unsigned n;
        // a zero bound is taken as one
        if (bound_a == '0)
            bound_a = t_bound'(1);
        if (bound_b == '0)
            bound_b = t_bound'(1);
        if (bound_b < bound_a) begin
            lo = bound_b;
            hi = bound_a;
        end else begin
            lo = bound_a;
            hi = bound_b;
        end
        best      = walk_cycle_length(lo);
        scan_from = hi / 2 + 1;
        if (scan_from < lo)
            scan_from = lo;
        for (n = scan_from; n <= hi; n++) begin
            cur = walk_cycle_length(t_bound'(n));
            if (cur > best)
                best = cur;
        end
        return t_len'(sat_len(best));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (memo_len[i])
                memo_len[i] = '0;
            expected_len_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_len = i_m_tdata[LEN_W-1:0];
                if (expected_len_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("%0t: result %0d with no request waiting", $time, got_len);
                    fail_cnt++;
                end else begin
                    want_len = expected_len_q.pop_front();
                    if (got_len != want_len) begin
                        if (fail_cnt < 10)
                            $display("%0t: max_cycle_length expected %0d, actual %0d",
                                     $time, want_len, got_len);
                        fail_cnt++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_len_q.push_back(range_max_length(i_s_tdata[19:0], i_s_tdata[39:20]));
        end
        o_pending    <= expected_len_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// File: tb/collatz_max_cycle_length_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collatz_max_cycle_length_unit_tb
// range requests against the collatz max cycle length unit
// ----------------------------------------------------------------------------
// a directed set covers zero and full-scale bounds, swapped and equal bounds,
// power-of-two and long-trajectory starts and memo reuse; random requests
// follow, mostly narrow ranges so every scan stays short. both sides idle at
// random, the output side holds off once for a long stretch and the input
// side pauses once until all results are back. checking lives in the checker
// ----------------------------------------------------------------------------
module collatz_max_cycle_length_unit_tb;
    import clm_pkg::*;

    localparam int IDLE_LIMIT = 300000;
    localparam int LONG_HOLD  = 2500;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // first_bound[19:0], second_bound[39:20]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // max_cycle_length[9:0], zero fill

    int   fail_count;
    int   pending;
    int   req_sent     = 0;
    int   results_rcvd = 0;
    int   idle_cycles  = 0;
    int   widest_span  = 0;
    logic no_idle      = 1'b0;
    logic hold_done    = 1'b0;

    int     i;
    int     pick;
    int     gap;
    int     span;
    t_bound lo;
    t_bound hi;

    always #5 i_clk = ~i_clk;

    collatz_max_cycle_length_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    collatz_max_cycle_length_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 80);
    endfunction

    task automatic send_request(input t_bound first_b, input t_bound second_b);
        int wait_gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {second_b, first_b};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        req_sent++;
        span = (first_b > second_b) ? int'(first_b - second_b) : int'(second_b - first_b);
        if (span > widest_span)
            widest_span = span;
        wait_gap = no_idle ? 0 : pick_gap();
        if (wait_gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (wait_gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            results_rcvd <= results_rcvd + 1;
    end

    // no handshake on either side for too long ends the run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // output side
    initial begin
        while (!i_rst_n)
            @(posedge i_clk);
        m_axis_tready <= 1'b1;
        forever begin
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
            if (!hold_done && results_rcvd >= 35) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                gap = no_idle ? 0 : pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_request(20'd1, 20'd1);
        send_request(20'd0, 20'd0);
        send_request(20'd0, 20'd5);
        send_request(20'd5, 20'd0);
        send_request(20'd2, 20'd2);
        send_request(20'd3, 20'd3);
        send_request(20'd1, 20'd10);
        send_request(20'd10, 20'd1);
        send_request(20'd27, 20'd27);
        send_request(20'd100, 20'd200);
        send_request(20'd210, 20'd201);
        send_request(20'd1, 20'd1000);
        send_request(20'd1000, 20'd1000);
        send_request(20'd1023, 20'd1024);
        send_request(20'd1024, 20'd1023);
        send_request(20'd524288, 20'd524288);
        send_request(20'd837799, 20'd837799);
        send_request(20'd999999, 20'd999990);
        send_request(20'hFFFFF, 20'hFFFFF);
        send_request(20'hFFFFF, 20'hFFFF0);
        send_request(20'hFFFF0, 20'hFFFFF);
        send_request(20'h55555, 20'h55555);
        send_request(20'hAAAAA, 20'hAAAAA);
        wait_drain();

        // random
        for (i = 0; i < 100; i++) begin
            if (i % 25 == 10)
                no_idle = 1'b1;
            if (i % 25 == 18)
                no_idle = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                hi = t_bound'($urandom_range(1, 160));
                lo = t_bound'($urandom_range(0, hi));
            end else if (pick < 65) begin
                hi   = t_bound'($urandom);
                span = $urandom_range(0, 40);
                lo   = (hi > span) ? hi - t_bound'(span) : '0;
            end else if (pick < 80) begin
                hi = t_bound'($urandom_range(100, 400));
                lo = t_bound'($urandom_range(0, 50));
            end else if (pick < 92) begin
                hi = t_bound'($urandom);
                lo = hi;
            end else begin
                hi = t_bound'($urandom);
                lo = hi ^ t_bound'($urandom_range(0, 31));
            end
            if ($urandom_range(0, 1))
                send_request(lo, hi);
            else
                send_request(hi, lo);
        end
        no_idle = 1'b0;

        wait_drain();
        repeat (200) @(posedge i_clk);

        $display("covered %0d range requests and %0d results, widest bound span %0d",
                 req_sent, results_rcvd, widest_span);
        $display("zero and full-scale bounds, swapped order, long output stall, drain pause");
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
